@@ rtl/sbpf_pkg.sv @@
// Shared types, constants and the microcode ROM of the servo bus packet framer.
// Used by the sequencer, the top level and the checker; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sbpf_pkg;

  localparam int MAX_MOTORS_DEF = 16;
  localparam int COUNT_W        = 5;
  localparam int PC_W           = 6;

  localparam logic [15:0] CRC_POLY       = 16'h8005;
  localparam logic [15:0] SYNC_LEN_BASE  = 16'd7;
  localparam logic [15:0] SYNC_ENTRY_LEN = 16'd5;

  localparam logic [7:0] HDR_FF        = 8'hFF;
  localparam logic [7:0] HDR_FD        = 8'hFD;
  localparam logic [7:0] LEN_TORQUE    = 8'h06;
  localparam logic [7:0] LEN_GOAL      = 8'h09;
  localparam logic [7:0] INST_WRITE    = 8'h03;
  localparam logic [7:0] INST_SYNC     = 8'h83;
  localparam logic [7:0] ADDR_TORQUE   = 8'h40;
  localparam logic [7:0] ADDR_GOAL     = 8'h74;
  localparam logic [7:0] BCAST_ID      = 8'hFE;
  localparam logic [7:0] DATA_LEN      = 8'h04;
  localparam logic [7:0] TORQUE_ENABLE = 8'h01;

  localparam logic [PC_W-1:0] PC_TORQUE     = 6'd0;
  localparam logic [PC_W-1:0] PC_GOAL       = 6'd13;
  localparam logic [PC_W-1:0] PC_SYNC_HEAD  = 6'd29;
  localparam logic [PC_W-1:0] PC_SYNC_ENTRY = 6'd41;

  typedef enum logic [1:0] {
    OP_TORQUE = 2'd0,
    OP_GOAL   = 2'd1,
    OP_SYNC   = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    SRC_CONST,
    SRC_ID,
    SRC_LENL,
    SRC_LENH,
    SRC_POS0,
    SRC_POS1,
    SRC_POS2,
    SRC_POS3,
    SRC_ENTID,
    SRC_CRCL,
    SRC_CRCH
  } src_t;

  typedef struct packed {
    src_t       src;
    logic [7:0] konst;
    logic       crc_clear;
    logic       crc_upd;
    logic       pkt_end;
    logic       fin;
    logic       fin_nl;
  } ctrl_t;

  typedef struct packed {
    logic  busy;
    logic  fire;
    logic  run_end;
    ctrl_t ctrl;
  } step_t;

  typedef logic [15:0] crc_tab_t [256];

  function automatic crc_tab_t crc_lut_gen();
    crc_tab_t    t;
    logic [15:0] c;
    for (int i = 0; i < 256; i++) begin
      c = 16'(i) << 8;
      for (int k = 0; k < 8; k++) begin
        c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      t[i] = c;
    end
    return t;
  endfunction

  localparam crc_tab_t CRC_LUT = crc_lut_gen();

  function automatic ctrl_t mk(src_t s, logic [7:0] k, logic clr, logic pend, logic fin,
                               logic fnl);
    ctrl_t w;
    w.src       = s;
    w.konst     = k;
    w.crc_clear = clr;
    w.crc_upd   = !(s == SRC_CRCL || s == SRC_CRCH);
    w.pkt_end   = pend;
    w.fin       = fin;
    w.fin_nl    = fnl;
    return w;
  endfunction

  function automatic ctrl_t kb(logic [7:0] k);
    return mk(SRC_CONST, k, 1'b0, 1'b0, 1'b0, 1'b0);
  endfunction

  function automatic ctrl_t sb(src_t s);
    return mk(s, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
  endfunction

  function automatic ctrl_t rom(logic [PC_W-1:0] pc);
    ctrl_t w;
    case (pc)
      // torque enable write
      6'd0:    w = mk(SRC_CONST, HDR_FF, 1'b1, 1'b0, 1'b0, 1'b0);
      6'd1:    w = kb(HDR_FF);
      6'd2:    w = kb(HDR_FD);
      6'd3:    w = kb(8'h00);
      6'd4:    w = sb(SRC_ID);
      6'd5:    w = kb(LEN_TORQUE);
      6'd6:    w = kb(8'h00);
      6'd7:    w = kb(INST_WRITE);
      6'd8:    w = kb(ADDR_TORQUE);
      6'd9:    w = kb(8'h00);
      6'd10:   w = kb(TORQUE_ENABLE);
      6'd11:   w = sb(SRC_CRCL);
      6'd12:   w = mk(SRC_CRCH, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0);
      // goal position write
      6'd13:   w = mk(SRC_CONST, HDR_FF, 1'b1, 1'b0, 1'b0, 1'b0);
      6'd14:   w = kb(HDR_FF);
      6'd15:   w = kb(HDR_FD);
      6'd16:   w = kb(8'h00);
      6'd17:   w = sb(SRC_ID);
      6'd18:   w = kb(LEN_GOAL);
      6'd19:   w = kb(8'h00);
      6'd20:   w = kb(INST_WRITE);
      6'd21:   w = kb(ADDR_GOAL);
      6'd22:   w = kb(8'h00);
      6'd23:   w = sb(SRC_POS0);
      6'd24:   w = sb(SRC_POS1);
      6'd25:   w = sb(SRC_POS2);
      6'd26:   w = sb(SRC_POS3);
      6'd27:   w = sb(SRC_CRCL);
      6'd28:   w = mk(SRC_CRCH, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0);
      // sync write header
      6'd29:   w = mk(SRC_CONST, HDR_FF, 1'b1, 1'b0, 1'b0, 1'b0);
      6'd30:   w = kb(HDR_FF);
      6'd31:   w = kb(HDR_FD);
      6'd32:   w = kb(8'h00);
      6'd33:   w = kb(BCAST_ID);
      6'd34:   w = sb(SRC_LENL);
      6'd35:   w = sb(SRC_LENH);
      6'd36:   w = kb(INST_SYNC);
      6'd37:   w = kb(ADDR_GOAL);
      6'd38:   w = kb(8'h00);
      6'd39:   w = kb(DATA_LEN);
      6'd40:   w = kb(8'h00);
      // sync write entry, then close on the last one
      6'd41:   w = sb(SRC_ENTID);
      6'd42:   w = sb(SRC_POS0);
      6'd43:   w = sb(SRC_POS1);
      6'd44:   w = sb(SRC_POS2);
      6'd45:   w = mk(SRC_POS3, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
      6'd46:   w = sb(SRC_CRCL);
      6'd47:   w = mk(SRC_CRCH, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0);
      default: w = mk(SRC_CONST, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ rtl/sbpf_seq.sv @@
// Microcode sequencer of the servo bus packet framer: step counter, ROM, branches.
// Depends on sbpf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbpf_seq (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  input  wire [1:0]           in_op,
  input  wire                 sync_open,
  input  wire                 out_free,
  input  wire                 last_entry,
  output sbpf_pkg::step_t     st
);

  logic                         busy;
  logic [sbpf_pkg::PC_W-1:0]    pc;
  logic [sbpf_pkg::PC_W-1:0]    entry_pc;
  sbpf_pkg::ctrl_t              ctrl;
  logic                         fire;
  logic                         done;

  always_comb begin
    ctrl = sbpf_pkg::rom(pc);
    fire = busy & out_free;
    done = ctrl.fin | (ctrl.fin_nl & ~last_entry);
    case (in_op)
      sbpf_pkg::OP_TORQUE: entry_pc = sbpf_pkg::PC_TORQUE;
      sbpf_pkg::OP_GOAL:   entry_pc = sbpf_pkg::PC_GOAL;
      default:             entry_pc = sync_open ? sbpf_pkg::PC_SYNC_ENTRY
                                                : sbpf_pkg::PC_SYNC_HEAD;
    endcase
    st.busy    = busy;
    st.fire    = fire;
    st.run_end = done;
    st.ctrl    = ctrl;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= '0;
    end else if (start) begin
      busy <= 1'b1;
      pc   <= entry_pc;
    end else if (fire) begin
      if (done) begin
        busy <= 1'b0;
      end else begin
        pc <= pc + sbpf_pkg::PC_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/servo_bus_packet_framer.sv @@
// Servo bus instruction packet framer: top level with the byte datapath and CRC.
// Depends on sbpf_pkg and sbpf_seq.
//
// Use: one item on the s_axis channel (operation, motor id, goal position) turns
// into a burst of packet bytes on m_axis, one byte per item there. tlast marks
// the last byte caused by an input item, tuser marks the CRC high byte that
// ends a packet. The user must write the motor count for sync writes through
// cfg_we and cfg_wdata only while the block is idle; the block does not enforce
// this. An operation code of 3 is taken and dropped. An item loads the
// sequencer's pc; its first byte then enters the output register. Torque enable
// yields 13 bytes, a goal position 16, a sync-write entry 5 to 19. The microcode
// step counter emits one byte per cycle; when the receiver stalls, the output
// register holds its byte and the sequencer waits. s_axis_tready is low while a
// burst is being sent. Reset clears the CRC, closes any sync write, sets the
// motor count to 1 and empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module servo_bus_packet_framer #(
  parameter int MAX_MOTORS = sbpf_pkg::MAX_MOTORS_DEF
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire [47:0]                   s_axis_tdata,  // operation, target_id, goal_position
  output logic                         m_axis_tvalid,
  input  wire                          m_axis_tready,
  output logic [7:0]                   m_axis_tdata,  // out_byte
  output logic                         m_axis_tlast,  // run_end
  output logic                         m_axis_tuser,  // packet_end
  input  wire                          cfg_we,
  input  wire [sbpf_pkg::COUNT_W-1:0]  cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_MOTORS + 1);

  logic [sbpf_pkg::COUNT_W-1:0] motor_count;
  logic [7:0]                   item_id;
  logic [31:0]                  item_pos;
  logic [15:0]                  crc;
  logic [CNT_W-1:0]             entry_index;

  logic [1:0]                   in_op;
  logic                         accept;
  logic                         op_single;
  logic                         start;
  logic [31:0]                  cnt_wide;
  logic [CNT_W-1:0]             cnt_eff;
  logic [15:0]                  sync_len;
  logic                         last_entry;
  logic                         out_free;
  logic [7:0]                   byte_val;
  logic [15:0]                  crc_base;
  logic [15:0]                  crc_next;
  sbpf_pkg::step_t              st;

  assign in_op     = s_axis_tdata[1:0];
  assign accept    = s_axis_tvalid & s_axis_tready;
  assign op_single = (in_op == sbpf_pkg::OP_TORQUE) || (in_op == sbpf_pkg::OP_GOAL);
  assign start     = accept & (op_single || in_op == sbpf_pkg::OP_SYNC);
  assign out_free  = ~m_axis_tvalid | m_axis_tready;
  assign s_axis_tready = ~st.busy;

  always_comb begin
    if (motor_count == '0) begin
      cnt_wide = 32'd1;
    end else if (32'(motor_count) > 32'(MAX_MOTORS)) begin
      cnt_wide = 32'(MAX_MOTORS);
    end else begin
      cnt_wide = 32'(motor_count);
    end
    cnt_eff    = cnt_wide[CNT_W-1:0];
    sync_len   = sbpf_pkg::SYNC_LEN_BASE + sbpf_pkg::SYNC_ENTRY_LEN * 16'(cnt_eff);
    last_entry = ({1'b0, entry_index} + (CNT_W + 1)'(1)) >= {1'b0, cnt_eff};
  end

  sbpf_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .in_op      (in_op),
    .sync_open  (entry_index != '0),
    .out_free   (out_free),
    .last_entry (last_entry),
    .st         (st)
  );

  always_comb begin
    case (st.ctrl.src)
      sbpf_pkg::SRC_CONST: byte_val = st.ctrl.konst;
      sbpf_pkg::SRC_ID:    byte_val = item_id;
      sbpf_pkg::SRC_LENL:  byte_val = sync_len[7:0];
      sbpf_pkg::SRC_LENH:  byte_val = sync_len[15:8];
      sbpf_pkg::SRC_POS0:  byte_val = item_pos[7:0];
      sbpf_pkg::SRC_POS1:  byte_val = item_pos[15:8];
      sbpf_pkg::SRC_POS2:  byte_val = item_pos[23:16];
      sbpf_pkg::SRC_POS3:  byte_val = item_pos[31:24];
      sbpf_pkg::SRC_ENTID: byte_val = 8'(entry_index) + 8'd1;
      sbpf_pkg::SRC_CRCL:  byte_val = crc[7:0];
      sbpf_pkg::SRC_CRCH:  byte_val = crc[15:8];
      default:             byte_val = 8'h00;
    endcase
    crc_base = st.ctrl.crc_clear ? 16'h0000 : crc;
    crc_next = {crc_base[7:0], 8'h00} ^ sbpf_pkg::CRC_LUT[crc_base[15:8] ^ byte_val];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      motor_count <= sbpf_pkg::COUNT_W'(1);
    end else if (cfg_we) begin
      motor_count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_id  <= s_axis_tdata[9:2];
      item_pos <= s_axis_tdata[41:10];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc         <= '0;
      entry_index <= '0;
    end else begin
      if (st.fire && st.ctrl.crc_upd) begin
        crc <= crc_next;
      end
      if (accept && op_single) begin
        entry_index <= '0;
      end else if (st.fire && st.ctrl.fin_nl) begin
        entry_index <= last_entry ? '0 : entry_index + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (st.fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st.fire) begin
      m_axis_tdata <= byte_val;
      m_axis_tlast <= st.run_end;
      m_axis_tuser <= st.ctrl.pkt_end;
    end
  end

endmodule

`default_nettype wire

@@ rtl/sbpf_checker.sv @@
// Port-level checks of the servo bus packet framer, bound to the top level.
// Depends on sbpf_pkg and servo_bus_packet_framer.
`timescale 1ns / 1ps
`default_nettype none

module sbpf_checker (
  input wire                          clk,
  input wire                          rst,
  input wire                          s_axis_tvalid,
  input wire                          s_axis_tready,
  input wire [47:0]                   s_axis_tdata,
  input wire                          m_axis_tvalid,
  input wire                          m_axis_tready,
  input wire [7:0]                    m_axis_tdata,
  input wire                          m_axis_tlast,
  input wire                          m_axis_tuser
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("output item changed while stalled");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("packet end not on the last byte of a run");

  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tdata[1:0] == sbpf_pkg::OP_TORQUE
      || s_axis_tdata[1:0] == sbpf_pkg::OP_GOAL || s_axis_tdata[1:0] == sbpf_pkg::OP_SYNC)
      |=> !s_axis_tready)
    else $error("input taken while a burst is running");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

bind servo_bus_packet_framer sbpf_checker u_sbpf_checker (.*);

`default_nettype wire

@@ bench/testbench.sv @@
// Testbench for servo_bus_packet_framer: drives instruction items, predicts every
// packet byte with its own CRC-16 framer and checks each output item. Depends on
// sbpf_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;

  localparam logic [1:0] OP_UNUSED      = 2'd3;
  localparam int         MOTOR_LIMIT    = sbpf_pkg::MAX_MOTORS_DEF;
  localparam int         RANDOM_ITEMS   = 200;
  localparam int         CALM_TAIL      = 40;
  localparam int         HOLD_CYCLES    = 300;
  localparam int         WATCHDOG_LIMIT = 2000;

  typedef struct {
    logic [7:0] data;
    logic       pend;
    logic       last;
  } pkt_byte_t;

  typedef struct {
    int          cfg;
    logic [1:0]  op;
    logic [7:0]  id;
    logic [31:0] pos;
    int          nbytes;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // operation[1:0], target_id[9:2], goal_position[41:10]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // out_byte
  logic        m_axis_tlast;        // run_end
  logic        m_axis_tuser;        // packet_end
  logic        cfg_we = 1'b0;
  logic [4:0]  cfg_wdata = '0;

  servo_bus_packet_framer uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  always #5 clk = ~clk;

  // predicted framer state
  logic [15:0] crc_acc   = '0;
  logic [4:0]  sync_idx  = '0;
  logic [4:0]  motor_cnt = 5'd1;

  pkt_byte_t   item_bytes_q[$];
  pkt_byte_t   pkt_bytes_q[$];
  pkt_byte_t   got;

  int mismatches     = 0;
  int items_taken    = 0;
  int bytes_checked  = 0;
  int packets_closed = 0;
  int count_writes   = 0;
  int quiet_cycles   = 0;
  bit idle_on        = 1'b1;
  bit hold_req       = 1'b0;

  function automatic logic [15:0] crc16_step(logic [15:0] c, logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      r = r[15] ? ((r << 1) ^ sbpf_pkg::CRC_POLY) : (r << 1);
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t mismatch: %s", $realtime, what);
    end
  endtask

  task automatic emit(input logic [7:0] b);
    crc_acc = crc16_step(crc_acc, b);
    item_bytes_q.push_back('{data: b, pend: 1'b0, last: 1'b0});
  endtask

  task automatic emit_head();
    crc_acc = '0;
    emit(sbpf_pkg::HDR_FF);
    emit(sbpf_pkg::HDR_FF);
    emit(sbpf_pkg::HDR_FD);
    emit(8'h00);
  endtask

  task automatic emit_pos(input logic [31:0] p);
    for (int i = 0; i < 4; i++) begin
      emit(p[8*i +: 8]);
    end
  endtask

  task automatic emit_crc();
    item_bytes_q.push_back('{data: crc_acc[7:0], pend: 1'b0, last: 1'b0});
    item_bytes_q.push_back('{data: crc_acc[15:8], pend: 1'b1, last: 1'b0});
  endtask

  // work out the bytes one accepted item causes and queue them
  task automatic frame_item(input logic [1:0] op, input logic [7:0] id,
                            input logic [31:0] pos, output int n);
    logic [4:0]  cnt;
    logic [15:0] len;
    item_bytes_q.delete();
    case (op)
      sbpf_pkg::OP_TORQUE: begin
        sync_idx = '0;
        emit_head();
        emit(id);
        emit(sbpf_pkg::LEN_TORQUE);
        emit(8'h00);
        emit(sbpf_pkg::INST_WRITE);
        emit(sbpf_pkg::ADDR_TORQUE);
        emit(8'h00);
        emit(sbpf_pkg::TORQUE_ENABLE);
        emit_crc();
      end
      sbpf_pkg::OP_GOAL: begin
        sync_idx = '0;
        emit_head();
        emit(id);
        emit(sbpf_pkg::LEN_GOAL);
        emit(8'h00);
        emit(sbpf_pkg::INST_WRITE);
        emit(sbpf_pkg::ADDR_GOAL);
        emit(8'h00);
        emit_pos(pos);
        emit_crc();
      end
      sbpf_pkg::OP_SYNC: begin
        cnt = (motor_cnt == 0) ? 5'd1
            : ((motor_cnt > MOTOR_LIMIT) ? 5'(MOTOR_LIMIT) : motor_cnt);
        if (sync_idx == 0) begin
          len = sbpf_pkg::SYNC_LEN_BASE + sbpf_pkg::SYNC_ENTRY_LEN * 16'(cnt);
          emit_head();
          emit(sbpf_pkg::BCAST_ID);
          emit(len[7:0]);
          emit(len[15:8]);
          emit(sbpf_pkg::INST_SYNC);
          emit(sbpf_pkg::ADDR_GOAL);
          emit(8'h00);
          emit(sbpf_pkg::DATA_LEN);
          emit(8'h00);
        end
        emit(8'(sync_idx + 5'd1));
        emit_pos(pos);
        sync_idx = sync_idx + 5'd1;
        if (sync_idx >= cnt) begin
          emit_crc();
          sync_idx = '0;
        end
      end
      default: ;
    endcase
    n = item_bytes_q.size();
    if (n > 0) begin
      item_bytes_q[n-1].last = 1'b1;
    end
    foreach (item_bytes_q[i]) pkt_bytes_q.push_back(item_bytes_q[i]);
  endtask

  task automatic send_item(input logic [1:0] op, input logic [7:0] id,
                           input logic [31:0] pos, output int n);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {6'b0, pos, id, op};
    do @(posedge clk); while (!s_axis_tready);
    items_taken++;
    frame_item(op, id, pos, n);
  endtask

  // write the count only once every expected byte is out and the block has settled
  task automatic write_motor_count(input logic [4:0] v);
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (pkt_bytes_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we    = 1'b0;
    motor_cnt = v;
    count_writes++;
  endtask

  function automatic logic [31:0] pick_pos();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'h0;
    if (r == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // receiver: random stalls, one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(1, 4) - 1) @(negedge clk);
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      bytes_checked++;
      if (m_axis_tuser) packets_closed++;
      if (pkt_bytes_q.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h tuser %b tlast %b",
                                  m_axis_tdata, m_axis_tuser, m_axis_tlast));
      end else begin
        got = pkt_bytes_q.pop_front();
        if (got.data !== m_axis_tdata || got.pend !== m_axis_tuser ||
            got.last !== m_axis_tlast) begin
          report_mismatch($sformatf(
            "byte exp %02h got %02h, tuser exp %b got %b, tlast exp %b got %b",
            got.data, m_axis_tdata, got.pend, m_axis_tuser, got.last, m_axis_tlast));
        end
      end
    end
  end

  // input handshakes, count writes and only expected output bytes count as progress
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || cfg_we ||
        (m_axis_tvalid && m_axis_tready && pkt_bytes_q.size() != 0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  plan_row_t plan [23];

  initial begin
    int         n;
    int         counted;
    int         r;
    int         k;
    logic [1:0] op;
    logic [4:0] cnt_val;

    plan = '{
      '{-1, sbpf_pkg::OP_TORQUE, 8'd0,   32'h0000_0000, 13},
      '{-1, sbpf_pkg::OP_GOAL,   8'd253, 32'hFFFF_FFFF, 16},
      '{-1, sbpf_pkg::OP_SYNC,   8'd0,   32'h1234_5678, 19},
      '{-1, OP_UNUSED,           8'd255, 32'hFFFF_FFFF, 0},
      '{-1, sbpf_pkg::OP_TORQUE, 8'd254, 32'h0000_0000, 13},
      '{-1, sbpf_pkg::OP_GOAL,   8'd255, 32'h0000_0000, 16},
      '{3,  sbpf_pkg::OP_SYNC,   8'd17,  32'hDEAD_BEEF, 17},
      '{-1, sbpf_pkg::OP_SYNC,   8'd0,   32'h0000_0000, 5},
      '{-1, sbpf_pkg::OP_SYNC,   8'd0,   32'hFFFF_FFFF, 7},
      '{-1, sbpf_pkg::OP_SYNC,   8'd1,   32'h8000_0001, 17},
      '{-1, sbpf_pkg::OP_TORQUE, 8'd2,   32'h0000_0000, 13},
      '{-1, sbpf_pkg::OP_SYNC,   8'd3,   32'h5555_AAAA, 17},
      '{-1, sbpf_pkg::OP_GOAL,   8'd128, 32'h0102_0304, 16},
      '{0,  sbpf_pkg::OP_SYNC,   8'd0,   32'h7FFF_FFFF, 19},
      '{31, sbpf_pkg::OP_SYNC,   8'd0,   32'h0000_FFFF, 17},
      '{2,  sbpf_pkg::OP_SYNC,   8'd0,   32'hFFFF_0000, 7},
      '{16, sbpf_pkg::OP_SYNC,   8'd0,   32'h0F0F_0F0F, 17},
      '{-1, OP_UNUSED,           8'd0,   32'h0000_0000, 0},
      '{-1, sbpf_pkg::OP_SYNC,   8'd0,   32'hF0F0_F0F0, 5},
      '{1,  sbpf_pkg::OP_SYNC,   8'd0,   32'h0000_0001, 7},
      '{17, sbpf_pkg::OP_SYNC,   8'd0,   32'h0000_0001, 17},
      '{-1, sbpf_pkg::OP_TORQUE, 8'd127, 32'h0000_0000, 13},
      '{1,  sbpf_pkg::OP_SYNC,   8'd0,   32'hAAAA_AAAA, 19}
    };

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (plan[i]) begin
      if (plan[i].cfg >= 0) write_motor_count(5'(plan[i].cfg));
      send_item(plan[i].op, plan[i].id, plan[i].pos, n);
      if (n != plan[i].nbytes) begin
        report_mismatch($sformatf("row %0d: %0d bytes predicted, table says %0d",
                                  i, n, plan[i].nbytes));
      end
    end

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      r = $urandom_range(0, 9);
      if (r < 7) cnt_val = 5'($urandom_range(1, 6));
      else if (r == 7) cnt_val = 5'($urandom_range(0, 31));
      else if (r == 8) cnt_val = 5'd0;
      else cnt_val = ($urandom_range(0, 1) == 0) ? 5'd16 : 5'd31;
      write_motor_count(cnt_val);
      if (counted == 0) hold_req = 1'b1;
      for (k = 0; k < 24 && counted < RANDOM_ITEMS; k++) begin
        idle_on = (counted < RANDOM_ITEMS - CALM_TAIL) && (k < 16);
        r = $urandom_range(0, 99);
        if (r < 65) op = sbpf_pkg::OP_SYNC;
        else if (r < 78) op = sbpf_pkg::OP_GOAL;
        else if (r < 91) op = sbpf_pkg::OP_TORQUE;
        else if (r < 95) op = OP_UNUSED;
        else op = sbpf_pkg::OP_SYNC;
        send_item(op, 8'($urandom_range(0, 255)), pick_pos(), n);
        if (op != OP_UNUSED) counted++;
      end
    end

    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (pkt_bytes_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d items, %0d bytes checked, %0d packets closed",
             items_taken, bytes_checked, packets_closed);
    $display("motor count written %0d times, extremes 0, 1, 16, 17 and 31 included",
             count_writes);
    if (mismatches == 0 && pkt_bytes_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d bytes still expected", mismatches, pkt_bytes_q.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule
